FILE: rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the SPI switch refresh sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

    localparam int TIME_BITS      = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [TIME_BITS-1:0] tstamp_t;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_OK   = 2'd2;
    localparam logic [1:0] MODE_FAIL = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_IO  = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic [2:0] PH_RESET = 3'd0;
    localparam logic [2:0] PH_IDLE  = 3'd1;
    localparam logic [2:0] PH_LOW   = 3'd2;
    localparam logic [2:0] PH_HIGH  = 3'd3;
    localparam logic [2:0] PH_EREQ  = 3'd4;
    localparam logic [2:0] PH_ECHK  = 3'd5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_TO_SLOW = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ECHO_STEP    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_CODE     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_CODE    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ECHO_CODE    = 3'd6;

    localparam logic [15:0] RST_FAST_PERIOD  = 16'd10;
    localparam logic [15:0] RST_SLOW_PERIOD  = 16'd100;
    localparam logic [15:0] RST_FAST_TO_SLOW = 16'd1000;
    localparam logic [15:0] RST_ECHO_STEP    = 16'd1;

    typedef struct packed {
        logic [15:0] fast_period;
        logic [15:0] slow_period;
        logic [15:0] fast_to_slow_time;
        logic [15:0] echo_step;
        logic [7:0]  low_write_code;
        logic [7:0]  high_write_code;
        logic [7:0]  echo_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] out_word;
        logic [15:0] response;
    } event_t;

    typedef struct packed {
        logic        frame_start;
        logic [7:0]  frame_ctrl;
        logic [7:0]  frame_data;
        logic        reset_release;
        logic [15:0] diag_low;
        logic [15:0] diag_high;
        logic [1:0]  link_status;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/srs_if.sv
// ----------------------------------------------------------------------------
// srs_if
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface srs_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] out_word;
    logic [15:0] response;

    modport source (output valid, output mode, output out_word, output response,
                    input ready);
    modport sink   (input valid, input mode, input out_word, input response,
                    output ready);
endinterface

interface srs_res_if;
    logic        valid;
    logic        ready;
    logic        frame_start;
    logic [7:0]  frame_ctrl;
    logic [7:0]  frame_data;
    logic        reset_release;
    logic [15:0] diag_low;
    logic [15:0] diag_high;
    logic [1:0]  link_status;

    modport source (output valid, output frame_start, output frame_ctrl,
                    output frame_data, output reset_release, output diag_low,
                    output diag_high, output link_status, input ready);
    modport sink   (input valid, input frame_start, input frame_ctrl,
                    input frame_data, input reset_release, input diag_low,
                    input diag_high, input link_status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srs_cfg_regs.sv
// ----------------------------------------------------------------------------
// srs_cfg_regs
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [srs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [srs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output srs_pkg::cfg_t                           cfg
);

    srs_pkg::cfg_t cfg_reg;
    srs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                srs_pkg::REG_FAST_PERIOD:  cfg_next.fast_period       = cfg_data;
                srs_pkg::REG_SLOW_PERIOD:  cfg_next.slow_period       = cfg_data;
                srs_pkg::REG_FAST_TO_SLOW: cfg_next.fast_to_slow_time = cfg_data;
                srs_pkg::REG_ECHO_STEP:    cfg_next.echo_step         = cfg_data;
                srs_pkg::REG_LOW_CODE:     cfg_next.low_write_code    = cfg_data[7:0];
                srs_pkg::REG_HIGH_CODE:    cfg_next.high_write_code   = cfg_data[7:0];
                srs_pkg::REG_ECHO_CODE:    cfg_next.echo_code         = cfg_data[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_period       <= srs_pkg::RST_FAST_PERIOD;
            cfg_reg.slow_period       <= srs_pkg::RST_SLOW_PERIOD;
            cfg_reg.fast_to_slow_time <= srs_pkg::RST_FAST_TO_SLOW;
            cfg_reg.echo_step         <= srs_pkg::RST_ECHO_STEP;
            cfg_reg.low_write_code    <= 8'd0;
            cfg_reg.high_write_code   <= 8'd0;
            cfg_reg.echo_code         <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/srs_seq_core.sv
// ----------------------------------------------------------------------------
// srs_seq_core
// Sequencer state and the single-step update applied to one event item.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_seq_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_en,
    input  wire srs_pkg::event_t evt,
    input  wire srs_pkg::cfg_t   cfg,
    output srs_pkg::result_t result
);

    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      wanted_reg, wanted_next;
    logic [15:0]      sent_reg, sent_next;
    logic             pending_reg, pending_next;
    logic             slow_reg, slow_next;
    srs_pkg::tstamp_t now_reg, now_next;
    srs_pkg::tstamp_t poll_reg, poll_next;
    srs_pkg::tstamp_t change_reg, change_next;
    logic [15:0]      echo_reg, echo_next;
    logic [15:0]      diag_lo_reg, diag_lo_next;
    logic [15:0]      diag_hi_reg, diag_hi_next;
    logic [1:0]       status_reg, status_next;

    logic             in_frame;
    logic             act;
    logic             start;
    logic [7:0]       ctrl;
    logic [7:0]       data;
    logic             rel;
    logic [15:0]      period;
    srs_pkg::tstamp_t since_poll;
    srs_pkg::tstamp_t since_change;

    assign in_frame = (phase_reg >= srs_pkg::PH_LOW) && (phase_reg <= srs_pkg::PH_ECHK);

    always_comb
    begin
        phase_next   = phase_reg;
        wanted_next  = wanted_reg;
        sent_next    = sent_reg;
        pending_next = pending_reg;
        slow_next    = slow_reg;
        now_next     = now_reg;
        poll_next    = poll_reg;
        change_next  = change_reg;
        echo_next    = echo_reg;
        diag_lo_next = diag_lo_reg;
        diag_hi_next = diag_hi_reg;
        status_next  = status_reg;
        act          = 1'b1;
        start        = 1'b0;
        ctrl         = 8'd0;
        data         = 8'd0;
        rel          = 1'b0;
        period       = cfg.fast_period;
        since_poll   = '0;
        since_change = now_reg - change_reg;

        case (evt.mode)
            srs_pkg::MODE_TICK:
            begin
                now_next = now_reg + srs_pkg::tstamp_t'(1);
            end
            srs_pkg::MODE_WORD:
            begin
                if (evt.out_word != wanted_reg)
                begin
                    pending_next = 1'b1;
                end
                wanted_next = evt.out_word;
            end
            srs_pkg::MODE_FAIL:
            begin
                if (in_frame)
                begin
                    status_next = srs_pkg::ST_IO;
                    phase_next  = srs_pkg::PH_RESET;
                end
            end
            default:
            begin
                if (in_frame)
                begin
                    act = 1'b0;
                    unique case (phase_reg)
                        srs_pkg::PH_LOW:
                        begin
                            start      = 1'b1;
                            ctrl       = cfg.high_write_code;
                            data       = sent_reg[15:8];
                            phase_next = srs_pkg::PH_HIGH;
                        end
                        srs_pkg::PH_HIGH:
                        begin
                            diag_lo_next = ~evt.response;
                            start        = 1'b1;
                            ctrl         = cfg.echo_code;
                            data         = sent_reg[15:8];
                            phase_next   = srs_pkg::PH_EREQ;
                        end
                        srs_pkg::PH_EREQ:
                        begin
                            diag_hi_next = ~evt.response;
                            start        = 1'b1;
                            ctrl         = echo_reg[15:8];
                            data         = echo_reg[7:0];
                            phase_next   = srs_pkg::PH_ECHK;
                        end
                        default:
                        begin
                            if (evt.response == echo_reg)
                            begin
                                echo_next   = echo_reg + cfg.echo_step;
                                status_next = srs_pkg::ST_OK;
                            end
                            else
                            begin
                                status_next = srs_pkg::ST_BAD;
                            end
                            poll_next  = now_reg;
                            phase_next = srs_pkg::PH_IDLE;
                            if (!slow_reg && (since_change >=
                                srs_pkg::tstamp_t'(cfg.fast_to_slow_time)))
                            begin
                                slow_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase

        if (act)
        begin
            if (phase_next == srs_pkg::PH_RESET)
            begin
                rel          = 1'b1;
                pending_next = 1'b1;
                phase_next   = srs_pkg::PH_IDLE;
            end
            else if (phase_next == srs_pkg::PH_IDLE)
            begin
                period     = (slow_next && !pending_next) ? cfg.slow_period
                                                          : cfg.fast_period;
                since_poll = now_next - poll_next;
                if (pending_next || (since_poll >= srs_pkg::tstamp_t'(period)))
                begin
                    if (pending_next)
                    begin
                        slow_next   = 1'b0;
                        change_next = now_next;
                    end
                    sent_next    = wanted_next;
                    pending_next = 1'b0;
                    phase_next   = srs_pkg::PH_LOW;
                    start        = 1'b1;
                    ctrl         = cfg.low_write_code;
                    data         = wanted_next[7:0];
                end
            end
        end

        result.frame_start   = start;
        result.frame_ctrl    = ctrl;
        result.frame_data    = data;
        result.reset_release = rel;
        result.diag_low      = diag_lo_next;
        result.diag_high     = diag_hi_next;
        result.link_status   = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= srs_pkg::PH_RESET;
            wanted_reg  <= '0;
            sent_reg    <= '0;
            pending_reg <= 1'b0;
            slow_reg    <= 1'b0;
            now_reg     <= '0;
            poll_reg    <= '0;
            change_reg  <= '0;
            echo_reg    <= '0;
            diag_lo_reg <= '0;
            diag_hi_reg <= '0;
            status_reg  <= srs_pkg::ST_OK;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            wanted_reg  <= wanted_next;
            sent_reg    <= sent_next;
            pending_reg <= pending_next;
            slow_reg    <= slow_next;
            now_reg     <= now_next;
            poll_reg    <= poll_next;
            change_reg  <= change_next;
            echo_reg    <= echo_next;
            diag_lo_reg <= diag_lo_next;
            diag_hi_reg <= diag_hi_next;
            status_reg  <= status_next;
        end
    end

`ifndef SYNTHESIS
    a_fail_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (evt.mode == srs_pkg::MODE_FAIL) && in_frame |=>
        (phase_reg == srs_pkg::PH_IDLE) && (status_reg == srs_pkg::ST_IO))
        else $error("failed frame did not end in idle with io error");

    a_echo_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (evt.mode == srs_pkg::MODE_OK) && (phase_reg == srs_pkg::PH_ECHK) |=>
        (phase_reg == srs_pkg::PH_IDLE) && (status_reg != srs_pkg::ST_IO))
        else $error("echo check did not return to idle");

    a_refresh_start: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.frame_start && (phase_reg == srs_pkg::PH_IDLE) |=>
        (phase_reg == srs_pkg::PH_LOW) && !pending_reg)
        else $error("refresh start did not enter the low-byte frame");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(echo_reg) && $stable(now_reg))
        else $error("sequencer state changed without an item");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/spi_switch_refresh_sequencer.sv
// ----------------------------------------------------------------------------
// spi_switch_refresh_sequencer
// Refresh frame sequencer for a 16-channel SPI low-side switch.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake       Payload
// evt       in         valid/ready     mode, out_word, response
// res       out        valid/ready     frame_start, frame_ctrl, frame_data,
//                                      reset_release, diag_low, diag_high,
//                                      link_status
// cfg       in         cfg_we only     cfg_index, cfg_data
//
// One item is accepted per cycle while the result is not stalled; it passes from
// the input register through the sequencer core into the result register, from
// which the result can be taken.
// The rate is set by the state update in the sequencer core.
// Reset clears the valid flags, configuration and core state at once, not the
// input and result data registers; no clearing pass is needed. A stalled result
// holds in the result register while one more item waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_switch_refresh_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [srs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [srs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    srs_evt_if.sink                                 evt,
    srs_res_if.source                               res
);

    srs_pkg::cfg_t    cfg;
    srs_pkg::event_t  evt_reg;
    srs_pkg::result_t step_result;
    srs_pkg::result_t res_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             step_en;
    logic             take;

    srs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srs_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .evt     (evt_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign advance   = !out_valid_reg || res.ready;
    assign step_en   = in_valid_reg && advance;
    assign evt.ready = !in_valid_reg || step_en;
    assign take      = evt.valid && evt.ready;

    always_comb
    begin
        in_valid_next  = take || (in_valid_reg && !step_en);
        out_valid_next = advance ? step_en : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            evt_reg.mode     <= evt.mode;
            evt_reg.out_word <= evt.out_word;
            evt_reg.response <= evt.response;
        end
        if (step_en)
        begin
            res_reg <= step_result;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.frame_start   = res_reg.frame_start;
    assign res.frame_ctrl    = res_reg.frame_ctrl;
    assign res.frame_data    = res_reg.frame_data;
    assign res.reset_release = res_reg.reset_release;
    assign res.diag_low      = res_reg.diag_low;
    assign res.diag_high     = res_reg.diag_high;
    assign res.link_status   = res_reg.link_status;

endmodule

`default_nettype wire
